// ===== hdl/hrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, character codes and character-class functions for the
// HTTP request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Parser states, one-hot
  typedef enum logic [20:0] {
    S_METHOD_START = 21'h000001,
    S_METHOD       = 21'h000002,
    S_URI_START    = 21'h000004,
    S_URI          = 21'h000008,
    S_VER_H        = 21'h000010,
    S_VER_T1       = 21'h000020,
    S_VER_T2       = 21'h000040,
    S_VER_P        = 21'h000080,
    S_VER_SLASH    = 21'h000100,
    S_MAJOR_START  = 21'h000200,
    S_MAJOR        = 21'h000400,
    S_MINOR_START  = 21'h000800,
    S_MINOR        = 21'h001000,
    S_NL1          = 21'h002000,
    S_LINE_START   = 21'h004000,
    S_LWS          = 21'h008000,
    S_NAME         = 21'h010000,
    S_SP_VALUE     = 21'h020000,
    S_VALUE        = 21'h040000,
    S_NL2          = 21'h080000,
    S_NL3          = 21'h100000
  } state_t;

  // Operation codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Status codes
  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;

  // Field classes
  localparam logic [2:0] FC_NONE   = 3'd0;
  localparam logic [2:0] FC_METHOD = 3'd1;
  localparam logic [2:0] FC_URI    = 3'd2;
  localparam logic [2:0] FC_NAME   = 3'd3;
  localparam logic [2:0] FC_VALUE  = 3'd4;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CTL_MAX  = 8'h1F;
  localparam logic [7:0] SAT_MAX  = 8'hFF;

  // One result beat
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] field_class;
    logic       starts_header;
    logic [7:0] byte_out;
    logic [7:0] major_version;
    logic [7:0] minor_version;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,           // ( ) < > @
      8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,           // , ; : \ "
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,           // / [ ] ? =
      8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;        // { } SP HT
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_special(c);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc*10 + digit, saturated to 8 bits
  function automatic logic [7:0] dec_acc(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, c[3:0]};
    return (v > 12'd255) ? SAT_MAX : v[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hrp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_step
// Parser state registers and the per-byte transition logic. Produces one
// result per accepted beat.
// ----------------------------------------------------------------------------
module hrp_step
  import hrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output result_t         res
);

  state_t     state_r, state_nxt;
  logic       header_seen_r, header_seen_nxt;
  logic [7:0] major_r, major_nxt;
  logic [7:0] minor_r, minor_nxt;

  logic       bad;
  logic [1:0] status;
  logic [2:0] cls;
  logic       starts;
  logic       is_lws;
  logic [7:0] major_dec, minor_dec;

  assign is_lws    = (data_byte == CH_SP) || (data_byte == CH_TAB);
  assign major_dec = dec_acc(major_r, data_byte);
  assign minor_dec = dec_acc(minor_r, data_byte);

  // Transition and classification
  always_comb begin
    state_nxt       = state_r;
    header_seen_nxt = header_seen_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    bad             = 1'b0;
    status          = ST_INCOMPLETE;
    cls             = FC_NONE;
    starts          = 1'b0;

    unique case (state_r)
      S_METHOD_START: begin
        if (is_token(data_byte)) begin
          state_nxt = S_METHOD;
          cls       = FC_METHOD;
        end else bad = 1'b1;
      end
      S_METHOD: begin
        if (data_byte == CH_SP) state_nxt = S_URI_START;
        else if (is_token(data_byte)) cls = FC_METHOD;
        else bad = 1'b1;
      end
      S_URI_START: begin
        if (is_ctl(data_byte)) bad = 1'b1;
        else begin
          state_nxt = S_URI;
          cls       = FC_URI;
        end
      end
      S_URI: begin
        if (data_byte == CH_SP) state_nxt = S_VER_H;
        else if (is_ctl(data_byte)) bad = 1'b1;
        else cls = FC_URI;
      end
      S_VER_H: begin
        if (data_byte == CH_H) state_nxt = S_VER_T1; else bad = 1'b1;
      end
      S_VER_T1: begin
        if (data_byte == CH_T) state_nxt = S_VER_T2; else bad = 1'b1;
      end
      S_VER_T2: begin
        if (data_byte == CH_T) state_nxt = S_VER_P; else bad = 1'b1;
      end
      S_VER_P: begin
        if (data_byte == CH_P) state_nxt = S_VER_SLASH; else bad = 1'b1;
      end
      S_VER_SLASH: begin
        if (data_byte == CH_SLASH) begin
          major_nxt = '0;
          minor_nxt = '0;
          state_nxt = S_MAJOR_START;
        end else bad = 1'b1;
      end
      S_MAJOR_START: begin
        if (is_digit(data_byte)) begin
          major_nxt = major_dec;
          state_nxt = S_MAJOR;
        end else bad = 1'b1;
      end
      S_MAJOR: begin
        if (data_byte == CH_DOT) state_nxt = S_MINOR_START;
        else if (is_digit(data_byte)) major_nxt = major_dec;
        else bad = 1'b1;
      end
      S_MINOR_START: begin
        if (is_digit(data_byte)) begin
          minor_nxt = minor_dec;
          state_nxt = S_MINOR;
        end else bad = 1'b1;
      end
      S_MINOR: begin
        if (data_byte == CH_CR) state_nxt = S_NL1;
        else if (is_digit(data_byte)) minor_nxt = minor_dec;
        else bad = 1'b1;
      end
      S_NL1: begin
        if (data_byte == CH_LF) state_nxt = S_LINE_START; else bad = 1'b1;
      end
      S_LINE_START: begin
        if (data_byte == CH_CR) state_nxt = S_NL3;
        else if (header_seen_r && is_lws) state_nxt = S_LWS;
        else if (is_token(data_byte)) begin
          header_seen_nxt = 1'b1;
          cls             = FC_NAME;
          starts          = 1'b1;
          state_nxt       = S_NAME;
        end else bad = 1'b1;
      end
      S_LWS: begin
        // continuation line: skip leading white space
        if (data_byte == CH_CR) state_nxt = S_NL2;
        else if (is_lws) state_nxt = S_LWS;
        else if (is_ctl(data_byte)) bad = 1'b1;
        else begin
          state_nxt = S_VALUE;
          cls       = FC_VALUE;
        end
      end
      S_NAME: begin
        if (data_byte == CH_COLON) state_nxt = S_SP_VALUE;
        else if (is_token(data_byte)) cls = FC_NAME;
        else bad = 1'b1;
      end
      S_SP_VALUE: begin
        if (data_byte == CH_SP) state_nxt = S_VALUE; else bad = 1'b1;
      end
      S_VALUE: begin
        if (data_byte == CH_CR) state_nxt = S_NL2;
        else if (is_ctl(data_byte)) bad = 1'b1;
        else cls = FC_VALUE;
      end
      S_NL2: begin
        if (data_byte == CH_LF) state_nxt = S_LINE_START; else bad = 1'b1;
      end
      S_NL3: begin
        // stays here after completion
        if (data_byte == CH_LF) status = ST_COMPLETE; else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    // malformed byte: keep state, flag it
    if (bad) begin
      status = ST_MALFORMED;
      cls    = FC_NONE;
      starts = 1'b0;
    end

    res.status        = status;
    res.field_class   = cls;
    res.starts_header = starts;
    res.byte_out      = data_byte;
    res.major_version = major_nxt;
    res.minor_version = minor_nxt;

    // reset op overrides everything
    if (op == OP_RESET) begin
      state_nxt       = S_METHOD_START;
      header_seen_nxt = 1'b0;
      major_nxt       = '0;
      minor_nxt       = '0;
      res             = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_METHOD_START;
      header_seen_r <= 1'b0;
      major_r       <= '0;
      minor_r       <= '0;
    end else if (push) begin
      state_r       <= state_nxt;
      header_seen_r <= header_seen_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
    end
  end

  // A reset op returns to the start state with nothing remembered
  a_reset_op: assert property (@(posedge clk) disable iff (!rst_n)
    push && (op == OP_RESET) |=> (state_r == S_METHOD_START) && !header_seen_r
      && (major_r == 8'd0) && (minor_r == 8'd0))
    else $error("reset op did not clear parser state");

  // Completion is only reported from the final LF state
  a_complete_src: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status == ST_COMPLETE) |-> (state_r == S_NL3) && (op == OP_DATA))
    else $error("complete outside final LF state");

  // Header start only once header_seen is set for the next byte
  a_starts_seen: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.starts_header |=> header_seen_r && (state_r == S_NAME))
    else $error("header start did not enter name state");

endmodule
`default_nettype wire

// ===== hdl/hrp_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_skid
// Two-entry result buffer: an output register and a skid register, so the
// input side never waits on out_ready combinationally.
// ----------------------------------------------------------------------------
module hrp_skid
  import hrp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t din,
  output logic         can_push,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      dout
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_data_r;

  // Buffer control
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = din;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // Skid entry is only ever used behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  // A push into an empty buffer shows up at the output next cycle
  a_push_through: assert property (@(posedge clk) disable iff (!rst_n)
    push && !out_valid_r |=> out_valid_r && (out_data_r == $past(din)))
    else $error("beat lost on empty buffer");

  // A stalled output with a push parks the beat in the skid register
  a_push_park: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_valid_r && !out_ready |=> skid_valid_r
      && (skid_data_r == $past(din)))
    else $error("beat lost on stalled output");

endmodule
`default_nettype wire

// ===== hdl/http_request_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-serial HTTP request line and header checker with field tagging
// and running version numbers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    op, data_byte
//  out_     output     out_valid / out_ready  status, class, start, byte, versions
//
//  One beat in, one beat out. A new byte is taken every cycle while in_ready
//  is high; the result is registered in the output (or skid) register, and the
//  parse step itself is combinational off the parser state register.
//  Synchronous active-low reset puts the parser in the method start state
//  and empties the output buffer.
//  A stall on out_ready is absorbed by a one-entry skid register; in_ready
//  drops only while that entry is occupied.
// ----------------------------------------------------------------------------
module http_request_header_parser
  import hrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [2:0]      out_field_class,
  output logic            out_starts_header,
  output logic [7:0]      out_byte_out,
  output logic [7:0]      out_major_version,
  output logic [7:0]      out_minor_version
);

  logic    push;
  result_t step_res;
  result_t out_res;

  assign push = in_valid && in_ready;

  // Parser core
  hrp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .op        (in_op),
    .data_byte (in_data_byte),
    .res       (step_res)
  );

  // Result buffer
  hrp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (out_res)
  );

  assign out_status        = out_res.status;
  assign out_field_class   = out_res.field_class;
  assign out_starts_header = out_res.starts_header;
  assign out_byte_out      = out_res.byte_out;
  assign out_major_version = out_res.major_version;
  assign out_minor_version = out_res.minor_version;

endmodule
`default_nettype wire
